[hdl/i2c_eeprom_access_sequencer_assert.svh]
// Assertion macros shared by the sequencer modules.
`ifndef I2C_EEPROM_ACCESS_SEQUENCER_ASSERT_SVH
`define I2C_EEPROM_ACCESS_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define IEAS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define IEAS_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define IEAS_ASSERT(name, prop, msg)

`define IEAS_ASSERT_NEVER(name, expr, msg)

`endif

`endif

[hdl/iea_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iea_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int RES_MAX = 6;
    localparam int RES_CNT_W = 3;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_ERASE = 2'd2;
    localparam logic [1:0] ACT_REPLY = 2'd3;

    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_RSTART = 3'd2;
    localparam logic [2:0] CMD_STOP   = 3'd3;
    localparam logic [2:0] CMD_PUT    = 3'd4;
    localparam logic [2:0] CMD_GET    = 3'd5;

    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_NOACK  = 2'd2;

    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_OFFSET_MODE    = 1'b1;

    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
    localparam logic [2:0] OFFSET_MODE_RESET    = 3'd1;
    localparam logic [7:0] ERASE_BYTE           = 8'hff;

    typedef struct packed {
        logic [2:0] bus_cmd;
        logic [7:0] bus_byte;
        logic       get_nack_last;
        logic       wants_reply;
        logic [7:0] read_data;
        logic       read_valid;
        logic [1:0] status;
        logic       last;
    } res_t;

    typedef struct packed {
        logic                 load;
        logic [RES_CNT_W-1:0] count;
    } load_t;

endpackage

`default_nettype wire

[hdl/iea_step.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_eeprom_access_sequencer_assert.svh"

module iea_step
    import iea_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic                 cfg_index,
    input  wire logic [6:0]           cfg_data,
    input  wire logic                 take,
    input  wire logic [1:0]           action,
    input  wire logic [15:0]          offset,
    input  wire logic [15:0]          count,
    input  wire logic [7:0]           write_data,
    input  wire logic                 reply_nack,
    input  wire logic [7:0]           reply_byte,
    output res_t [RES_MAX-1:0]        list,
    output load_t                     ctl
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_RD_ADDR = 4'd1;
    localparam logic [3:0] PH_RD_GET  = 4'd2;
    localparam logic [3:0] PH_WR_ADDR = 4'd3;
    localparam logic [3:0] PH_WR_POLL = 4'd4;

    logic [6:0]             device_address_reg;
    logic [2:0]             offset_mode_reg;
    logic [3:0]             phase_reg;
    logic [3:0]             phase_next;
    logic [OFFSET_BITS-1:0] current_offset_reg;
    logic [OFFSET_BITS-1:0] current_offset_next;
    logic [15:0]            bytes_left_reg;
    logic [15:0]            bytes_left_next;
    logic [6:0]             bus_address_reg;
    logic [6:0]             bus_address_next;
    logic [7:0]             pending_byte_reg;
    logic [7:0]             pending_byte_next;

    logic [OFFSET_BITS-1:0] off_m;
    logic [15:0]            off16;
    logic [15:0]            cur16;
    logic [3:0]             high_mask;
    logic [6:0]             addr_calc;
    logic [15:0]            bytes_dec;
    logic [RES_CNT_W-1:0]   k;

    function automatic res_t mk(input logic [2:0] cmd, input logic [7:0] b,
                                input logic nack, input logic wants,
                                input logic [7:0] rd, input logic rv,
                                input logic [1:0] st);
        res_t r;
        r.bus_cmd       = cmd;
        r.bus_byte      = b;
        r.get_nack_last = nack;
        r.wants_reply   = wants;
        r.read_data     = rd;
        r.read_valid    = rv;
        r.status        = st;
        r.last          = 1'b0;
        return r;
    endfunction

    assign off_m = offset[OFFSET_BITS-1:0];
    assign off16 = 16'(off_m);
    assign cur16 = 16'(current_offset_reg);
    assign bytes_dec = bytes_left_reg - 16'd1;

    // In negative offset mode the low high-offset bits are merged into the address.
    always_comb
    begin
        case (offset_mode_reg)
            3'b100:  high_mask = 4'hf;
            3'b101:  high_mask = 4'h7;
            3'b110:  high_mask = 4'h3;
            3'b111:  high_mask = 4'h1;
            default: high_mask = 4'h0;
        endcase
        addr_calc = device_address_reg | {3'b000, off16[11:8] & high_mask};
    end

    always_comb
    begin
        phase_next          = phase_reg;
        current_offset_next = current_offset_reg;
        bytes_left_next     = bytes_left_reg;
        bus_address_next    = bus_address_reg;
        pending_byte_next   = pending_byte_reg;
        list                = '0;
        k                   = '0;
        if (action != ACT_REPLY)
        begin
            if (phase_reg == PH_IDLE)
            begin
                current_offset_next = off_m;
                bus_address_next    = addr_calc;
                if (action == ACT_READ)
                begin
                    bytes_left_next = (count == 16'd0) ? 16'd1 : count;
                    phase_next      = PH_RD_ADDR;
                end
                else
                begin
                    pending_byte_next = (action == ACT_WRITE) ? write_data : ERASE_BYTE;
                    phase_next        = PH_WR_ADDR;
                end
                list[0] = mk(CMD_START, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, ST_BUSY);
                list[1] = mk(CMD_PUT, {addr_calc, 1'b0}, 1'b0, 1'b1, 8'd0, 1'b0, ST_BUSY);
                k = 3'd2;
            end
        end
        else
        begin
            case (phase_reg)
                PH_RD_ADDR, PH_WR_ADDR:
                begin
                    if (reply_nack)
                    begin
                        list[0] = mk(CMD_STOP, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, ST_NOACK);
                        k = 3'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        if (offset_mode_reg == 3'd2)
                        begin
                            list[k] = mk(CMD_PUT, cur16[15:8], 1'b0, 1'b0, 8'd0, 1'b0,
                                         ST_BUSY);
                            k = k + 3'd1;
                        end
                        list[k] = mk(CMD_PUT, cur16[7:0], 1'b0, 1'b0, 8'd0, 1'b0, ST_BUSY);
                        k = k + 3'd1;
                        if (phase_reg == PH_RD_ADDR)
                        begin
                            list[k] = mk(CMD_RSTART, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, ST_BUSY);
                            k = k + 3'd1;
                            list[k] = mk(CMD_PUT, {bus_address_reg, 1'b1}, 1'b0, 1'b0,
                                         8'd0, 1'b0, ST_BUSY);
                            k = k + 3'd1;
                            list[k] = mk(CMD_GET, 8'd0, bytes_left_reg == 16'd1, 1'b1,
                                         8'd0, 1'b0, ST_BUSY);
                            k = k + 3'd1;
                            phase_next = PH_RD_GET;
                        end
                        else
                        begin
                            list[k] = mk(CMD_PUT, pending_byte_reg, 1'b0, 1'b0, 8'd0, 1'b0,
                                         ST_BUSY);
                            k = k + 3'd1;
                            list[k] = mk(CMD_STOP, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, ST_BUSY);
                            k = k + 3'd1;
                            list[k] = mk(CMD_START, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, ST_BUSY);
                            k = k + 3'd1;
                            list[k] = mk(CMD_PUT, {bus_address_reg, 1'b0}, 1'b0, 1'b1,
                                         8'd0, 1'b0, ST_BUSY);
                            k = k + 3'd1;
                            phase_next = PH_WR_POLL;
                        end
                    end
                end
                PH_RD_GET:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec != 16'd0)
                    begin
                        list[0] = mk(CMD_GET, 8'd0, bytes_dec == 16'd1, 1'b1, reply_byte,
                                     1'b1, ST_BUSY);
                    end
                    else
                    begin
                        list[0] = mk(CMD_STOP, 8'd0, 1'b0, 1'b0, reply_byte, 1'b1,
                                     ST_DONE);
                        phase_next = PH_IDLE;
                    end
                    k = 3'd1;
                end
                PH_WR_POLL:
                begin
                    if (reply_nack)
                    begin
                        list[0] = mk(CMD_STOP, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, ST_BUSY);
                        list[1] = mk(CMD_START, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, ST_BUSY);
                        list[2] = mk(CMD_PUT, {bus_address_reg, 1'b0}, 1'b0, 1'b1, 8'd0,
                                     1'b0, ST_BUSY);
                        k = 3'd3;
                    end
                    else
                    begin
                        list[0] = mk(CMD_STOP, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, ST_DONE);
                        k = 3'd1;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        if (k != 3'd0)
        begin
            list[k - 3'd1].last = 1'b1;
        end
    end

    assign ctl.load  = take;
    assign ctl.count = k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
            offset_mode_reg    <= OFFSET_MODE_RESET;
            phase_reg          <= PH_IDLE;
            current_offset_reg <= '0;
            bytes_left_reg     <= '0;
            bus_address_reg    <= '0;
            pending_byte_reg   <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_DEVICE_ADDRESS)
            begin
                device_address_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_OFFSET_MODE)
            begin
                offset_mode_reg <= cfg_data[2:0];
            end
            if (take)
            begin
                phase_reg          <= phase_next;
                current_offset_reg <= current_offset_next;
                bytes_left_reg     <= bytes_left_next;
                bus_address_reg    <= bus_address_next;
                pending_byte_reg   <= pending_byte_next;
            end
        end
    end

    // A read never waits on a fetch with nothing left to fetch.
    `IEAS_ASSERT_NEVER(a_get_count, phase_reg == PH_RD_GET && bytes_left_reg == 16'd0, "fetch phase with zero bytes left")
    `IEAS_ASSERT(a_request_busy, take && action != ACT_REPLY && phase_reg != PH_IDLE |=> $stable(phase_reg), "request while busy changed the phase")

endmodule

`default_nettype wire

[hdl/iea_burst.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_eeprom_access_sequencer_assert.svh"

module iea_burst
    import iea_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  res_t [RES_MAX-1:0]        list,
    input  load_t                     ctl,
    output logic                      ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output res_t                      result
);

    res_t [RES_MAX-1:0]   entries_reg;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_CNT_W-1:0] idx_reg;
    logic                 done_now;

    assign out_valid = idx_reg != count_reg;
    assign done_now  = out_valid && out_ready && idx_reg == count_reg - 3'd1;
    assign ready     = !out_valid || done_now;
    assign result    = entries_reg[idx_reg];

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entries_reg <= list;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                count_reg <= ctl.count;
                idx_reg   <= '0;
            end
            else if (out_valid && out_ready)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    `IEAS_ASSERT_NEVER(a_idx_range, idx_reg > count_reg, "result index beyond burst length")
    `IEAS_ASSERT(a_burst_continues, out_valid && out_ready && !result.last |=> out_valid, "burst ended before its last transfer")
    `IEAS_ASSERT(a_last_at_end, out_valid && result.last |-> idx_reg == count_reg - 3'd1, "last flag not on the final result")

endmodule

`default_nettype wire

[hdl/i2c_eeprom_access_sequencer.sv]
// An item's first result is registered, offered in the cycle after the item is accepted.
// An item giving k results (k is 0 to 6) holds the output until its last result is taken;
// items without results, or arriving as the last result leaves, are taken every cycle.
// The output burst register holds up to six results, so a new item waits for it to drain.
// Reset (rst_n, asynchronous, active low) idles the sequencer and restores both registers.
`timescale 1ns / 1ps
`default_nettype none

module i2c_eeprom_access_sequencer
    import iea_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] offset,
    input  wire logic [15:0] count,
    input  wire logic [7:0]  write_data,
    input  wire logic        reply_nack,
    input  wire logic [7:0]  reply_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       bus_cmd,
    output logic [7:0]       bus_byte,
    output logic             get_nack_last,
    output logic             wants_reply,
    output logic [7:0]       read_data,
    output logic             read_valid,
    output logic [1:0]       status,
    output logic             last
);

    res_t [RES_MAX-1:0] list;
    load_t              ctl;
    res_t               result;
    logic               take;

    assign take = in_valid && in_ready;

    iea_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .action     (action),
        .offset     (offset),
        .count      (count),
        .write_data (write_data),
        .reply_nack (reply_nack),
        .reply_byte (reply_byte),
        .list       (list),
        .ctl        (ctl)
    );

    iea_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .list      (list),
        .ctl       (ctl),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign bus_cmd       = result.bus_cmd;
    assign bus_byte      = result.bus_byte;
    assign get_nack_last = result.get_nack_last;
    assign wants_reply   = result.wants_reply;
    assign read_data     = result.read_data;
    assign read_valid    = result.read_valid;
    assign status        = result.status;
    assign last          = result.last;

endmodule

`default_nettype wire
